>>> rtl/bitmap_allocator_top_assert.svh
// Assertion macros for the bitmap allocator checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMALLOC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMALLOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");

`endif

>>> rtl/bmalloc_pkg.sv
// Package for the bitmap allocator: sizes, operation codes, state and result types, helper functions.
// No dependencies.
package bmalloc_pkg;

    localparam int MAX_BITS  = 1024;
    localparam int WORD_BITS = 32;
    localparam int NWORDS    = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = $clog2(NWORDS);
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int OP_W      = 3;
    localparam int POP_W     = $clog2(WORD_BITS + 1);

    localparam logic [OP_W-1:0] OP_MARK  = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             index_error;
        logic [CNT_W-1:0] free_count;
        logic [IDX_W-1:0] alloc_index;
        logic             alloc_found;
        logic             is_free;
    } result_t;

    function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + POP_W'(w[i]);
        end
        return n;
    endfunction

    function automatic logic [BIT_AW-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
        logic [BIT_AW-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i])
            begin
                n = n | BIT_AW'(i);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/bitmap_allocator_top.sv
// Bitmap allocator: a map of allocation bits held in a word memory with registered reads.
// Depends on bmalloc_pkg.
// Mark, clear and test: ST_RMW, then ST_DONE; a rejected index or code skips ST_RMW.
// Count and allocate: one word read per cycle in ST_SCAN, up to the last word of the map.
// One request at a time; s_tready rises in the same cycle as the result's m_tvalid.
// Reset: per-word valid flags clear the whole map at once; num_bits resets to 1024.
module bitmap_allocator_top
    import bmalloc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,     // num_bits
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // bit_index[9:0], zero padding
    input  logic [2:0]  s_tuser,      // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // is_free, alloc_found, alloc_index[9:0],
                                      // free_count[10:0], index_error
);

    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [NWORDS-1:0]    wvalid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     num_bits_reg;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_AW-1:0]   proc_reg, proc_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    result_t              res_reg, res_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [23:0]          m_tdata_reg, m_tdata_next;

    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     limit_m1;
    logic [WORD_AW-1:0]   last_word;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest_free;
    logic [WORD_BITS-1:0] bit_sel;
    logic                 out_free;

    assign limit     = (num_bits_reg > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : num_bits_reg;
    assign limit_m1  = limit - CNT_W'(1);
    assign last_word = limit_m1[WORD_AW+BIT_AW-1:BIT_AW];
    assign rd_word   = rd_valid_reg ? rd_data_reg : '0;
    assign word_mask = ({1'b0, proc_reg} < limit[CNT_W-1:BIT_AW]) ? '1 :
                       ~({WORD_BITS{1'b1}} << limit[BIT_AW-1:0]);
    assign free_bits   = ~rd_word & word_mask;
    assign lowest_free = free_bits & (~free_bits + WORD_BITS'(1));
    assign bit_sel     = WORD_BITS'(1) << idx_reg[BIT_AW-1:0];
    assign out_free    = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg   <= '0;
            rd_valid_reg <= 1'b0;
            state_reg    <= ST_IDLE;
            num_bits_reg <= CNT_W'(MAX_BITS);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                wvalid_reg[mem_waddr] <= 1'b1;
            end
            rd_valid_reg <= wvalid_reg[rd_addr];
            state_reg    <= state_next;
            if (cfg_we)
            begin
                num_bits_reg <= cfg_data;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        proc_reg    <= proc_next;
        count_reg   <= count_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        proc_next     = proc_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = proc_reg + WORD_AW'(1);
        mem_we        = 1'b0;
        mem_waddr     = proc_reg;
        mem_wdata     = rd_word;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = s_tdata[IDX_W-1:BIT_AW];
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    idx_next   = s_tdata[IDX_W-1:0];
                    res_next   = '0;
                    proc_next  = '0;
                    count_next = '0;
                    state_next = ST_DONE;
                    if (s_tuser inside {OP_MARK, OP_CLEAR, OP_TEST})
                    begin
                        if ({1'b0, s_tdata[IDX_W-1:0]} >= limit)
                        begin
                            res_next.index_error = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_RMW;
                        end
                    end
                    else if (s_tuser inside {OP_COUNT, OP_ALLOC})
                    begin
                        rd_addr = '0;
                        if (limit != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_RMW:
            begin
                mem_waddr  = idx_reg[IDX_W-1:BIT_AW];
                state_next = ST_DONE;
                case (op_reg)
                    OP_MARK:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_word | bit_sel;
                    end
                    OP_CLEAR:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_word & ~bit_sel;
                    end
                    default:
                    begin
                        res_next.is_free = ((rd_word & bit_sel) == '0);
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (op_reg == OP_COUNT)
                begin
                    count_next = count_reg + CNT_W'(popcount(free_bits));
                    if (proc_reg == last_word)
                    begin
                        res_next.free_count = count_next;
                        state_next          = ST_DONE;
                    end
                    else
                    begin
                        proc_next = proc_reg + WORD_AW'(1);
                    end
                end
                else
                begin
                    if (free_bits != '0)
                    begin
                        mem_we               = 1'b1;
                        mem_wdata            = rd_word | lowest_free;
                        res_next.alloc_found = 1'b1;
                        res_next.alloc_index = {proc_reg, onehot_index(lowest_free)};
                        state_next           = ST_DONE;
                    end
                    else if (proc_reg == last_word)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        proc_next = proc_reg + WORD_AW'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_reg.index_error, res_reg.free_count,
                                     res_reg.alloc_index, res_reg.alloc_found,
                                     res_reg.is_free};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bmalloc_checker.sv
// Port-level checker for the bitmap allocator, bound to the top level.
// Depends on bitmap_allocator_top_assert.svh and bmalloc_pkg.
`include "bitmap_allocator_top_assert.svh"

module bmalloc_checker
    import bmalloc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic oversized_count;

    assign oversized_count = m_tdata[22] && (m_tdata[21:12] != '0);

    // A held result keeps its contents.
    `BMALLOC_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Only one request is in flight at a time.
    `BMALLOC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // A rejected index never reports a free bit or an allocation.
    `BMALLOC_ASSERT_NOW(a_error_clean, m_tvalid && m_tdata[23], !m_tdata[0] && !m_tdata[1])

    // A failed allocation reports index zero.
    `BMALLOC_ASSERT_NOW(a_nofind_zero, m_tvalid && !m_tdata[1], m_tdata[11:2] == '0)

    // The free count never exceeds 1024, the largest map size.
    `BMALLOC_ASSERT_NOW(a_count_range, m_tvalid, !oversized_count)

endmodule

bind bitmap_allocator_top bmalloc_checker u_bmalloc_checker (.*);
